@@ src/assert_macros.svh @@
// Assertion macros used by the queue checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is high.
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/spq_pkg.sv @@
// Types and codes for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 5;

  // Operation kind carried in tuser
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_PEEK   = 2'd2
  } kind_t;

  // Result status
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  localparam logic signed [DATA_W-1:0] EMPTY_FRONT = -32'sd1;

  // One stored entry
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } slot_t;

  // Broadcast to every cell
  typedef struct packed {
    logic  insert;
    logic  remove;
    slot_t new_slot;
  } cell_ctrl_t;

endpackage

@@ src/spq_cell.sv @@
// One slot of the shift-register queue: compare, hold, take new or shift.
`timescale 1ns / 1ps

module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  spq_pkg::slot_t     left_slot,
  input  spq_pkg::slot_t     right_slot,
  input  logic               left_ge,
  input  logic               occupied,
  output logic               ge,
  output spq_pkg::slot_t     slot,
  output spq_pkg::slot_t     slot_next
);
  import spq_pkg::*;

  // Stored entry ranks ahead of the new one (ties keep arrival order)
  assign ge = occupied && (slot.prio >= ctrl.new_slot.prio);

  // Next contents
  always_comb begin
    slot_next = slot;
    if (ctrl.insert) begin
      if (!ge) begin
        slot_next = left_ge ? ctrl.new_slot : left_slot;
      end
    end else if (ctrl.remove) begin
      slot_next = right_slot;
    end
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

endmodule

@@ src/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: cell chain, count and result beat.
// Usage
//   Input beats on s_axis: tuser carries the kind (insert, remove, peek),
//   tdata carries the value and priority. Each input beat yields exactly one
//   result beat on m_axis with the front value after the operation (-1 when
//   empty), the entry count and a status code.
//   Entries live in a row of CAPACITY cells, highest priority in cell 0;
//   every cell compares its priority with the incoming one in parallel and
//   either holds, takes the new entry or takes its neighbor's entry.
// Timing
//   One item per cycle sustained while the receiver keeps up; the whole chain
//   updates in the cycle the beat is accepted, and the result is loaded into
//   the output register at the same clock edge.
//   s_axis_tready is high while the output register is empty or being
//   drained, so a stalled receiver holds the result and blocks new input
//   only while that register is full.
// Reset
//   rst (synchronous, active high) empties the queue and drops any pending
//   result; stored slot contents are not cleared and are never read while
//   unoccupied.
`timescale 1ns / 1ps

module sorted_priority_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [31:0] item_value, [63:32] item_priority
  input  logic [1:0]  s_axis_tuser,  // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // [31:0] front_value, [36:32] entry_count,
                                     // [38:37] status, [39] zero
);
  import spq_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;
  logic           accept;
  logic           full;
  logic           empty;
  status_t        status_next;
  cell_ctrl_t     ctrl;
  slot_t          slot_q    [CAPACITY];
  slot_t          slot_n    [CAPACITY];
  logic           ge        [CAPACITY];
  logic [CW+COUNT_W-1:0] count_ext;
  logic signed [DATA_W-1:0] front_next;

  // Handshake
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign full  = (count == CW'(CAPACITY));
  assign empty = (count == '0);

  // Decode the beat
  always_comb begin
    ctrl.insert         = 1'b0;
    ctrl.remove         = 1'b0;
    ctrl.new_slot.value = s_axis_tdata[31:0];
    ctrl.new_slot.prio  = s_axis_tdata[63:32];
    status_next         = STATUS_OK;
    count_next          = count;
    case (s_axis_tuser)
      KIND_INSERT: begin
        if (full) begin
          status_next = STATUS_FULL;
        end else begin
          ctrl.insert = accept;
          count_next  = count + CW'(1);
        end
      end
      KIND_REMOVE: begin
        if (empty) begin
          status_next = STATUS_EMPTY;
        end else begin
          ctrl.remove = accept;
          count_next  = count - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slot_t left_slot;
    slot_t right_slot;
    logic  left_ge;

    if (i == 0) begin : g_head
      assign left_slot = ctrl.new_slot;
      assign left_ge   = 1'b1;
    end else begin : g_body
      assign left_slot = slot_q[i-1];
      assign left_ge   = ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_slot = slot_q[i];
    end else begin : g_inner
      assign right_slot = slot_q[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .left_slot  (left_slot),
      .right_slot (right_slot),
      .left_ge    (left_ge),
      .occupied   (count > CW'(i)),
      .ge         (ge[i]),
      .slot       (slot_q[i]),
      .slot_next  (slot_n[i])
    );
  end

  // Result fields
  assign front_next = (count_next == '0) ? EMPTY_FRONT : slot_n[0].value;
  assign count_ext  = {{COUNT_W{1'b0}}, count_next};

  // Count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count         <= count_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {1'b0, status_next, count_ext[COUNT_W-1:0], front_next};
    end
  end

endmodule

@@ src/spq_checker.sv @@
// Port-level checks for the sorted priority queue, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spq_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic [39:0] m_axis_tdata
);
  import spq_pkg::*;

  logic [4:0] cap_field;
  assign cap_field = 5'(CAPACITY);

  // No result beat survives reset
  `SPQ_ASSERT_ALWAYS(a_reset_clears, rst |=> !m_axis_tvalid, "result valid after reset")

  // Empty queue always reports the empty marker
  `SPQ_ASSERT(a_empty_front, (m_axis_tvalid && m_axis_tdata[36:32] == 5'd0) |-> (m_axis_tdata[31:0] == 32'hFFFF_FFFF), "empty queue front not -1")

  // Remove on empty leaves an empty queue
  `SPQ_ASSERT(a_remove_empty, (m_axis_tvalid && m_axis_tdata[38:37] == STATUS_EMPTY) |-> (m_axis_tdata[36:32] == 5'd0), "empty status with entries")

  // Rejected insert only happens at capacity
  `SPQ_ASSERT(a_full_count, (m_axis_tvalid && m_axis_tdata[38:37] == STATUS_FULL) |-> (m_axis_tdata[36:32] == cap_field), "full status below capacity")

  // Status code stays in range
  `SPQ_ASSERT(a_status_code, m_axis_tvalid |-> (m_axis_tdata[38:37] != 2'd3), "bad status code")

endmodule

bind sorted_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tdata  (m_axis_tdata)
);
